@@ src/lru_pkg.sv @@
package lru_pkg;

    localparam int DEFAULT_LIST_DEPTH = 16;
    localparam int DEFAULT_ID_WIDTH   = 10;

    // Widths of the item fields at the ports
    localparam int PORT_ID_W  = 10;
    localparam int PORT_LEN_W = 5;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_MOVE   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SEARCH,
        S_SHIFT,
        S_PLACE
    } lru_state_t;

    typedef struct packed {
        logic [1:0]           operation;
        logic [PORT_ID_W-1:0] buffer_id;
    } request_t;

    typedef struct packed {
        logic [PORT_ID_W-1:0]  result_id;
        status_t               status;
        logic [PORT_LEN_W-1:0] length;
    } response_t;

endpackage

@@ src/lru_order_list.sv @@
// LRU order list: an ordered list of buffer ids kept for a buffer pool, used
// both as a free list and as a recency list.
// Request channel: an item (operation, buffer_id) is taken at a rising edge
// where start is high and busy is low. busy stays high until the result is
// out; one item is in work at a time.
// Response channel: done is high for exactly one cycle with result_id,
// status and length on response. The receiver cannot stall; the result is
// gone after that cycle. A new start is taken in the same cycle as done.
// Steps of an item: append, pop or move on an empty list, and the unused
// code, answer from the execute state; pop reads the head in a wait state;
// move walks from the head and answers when it finds the id at the tail or
// reaches the tail without a match, else it closes the gap and then writes
// the id into the last slot. The speed of search and shift is set by the
// single read port of the id store: the search reads one entry per cycle,
// and closing the gap moves one entry per cycle.
// The store is a circular buffer, so pop costs no shifting.
// Reset clears the entry count and pointers; the id store is not cleared,
// and only entries that were written are ever read.
module lru_order_list
    import lru_pkg::*;
#(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH,
    parameter int ID_WIDTH   = DEFAULT_ID_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  request_t  request,
    output logic      done,
    output response_t response
);

    localparam int PTR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(LIST_DEPTH - 1);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    // Circular advance over the store
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    // Id store and its ports
    logic [ID_WIDTH-1:0] id_store [LIST_DEPTH];
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [ID_WIDTH-1:0] wr_data;
    logic [PTR_W-1:0]    rd_addr;
    logic [ID_WIDTH-1:0] rd_data_reg;

    // Control state
    lru_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic             done_reg, done_next;

    // Working registers of the current item
    logic [1:0]          op_reg, op_next;
    logic [ID_WIDTH-1:0] id_reg, id_next;
    logic [PTR_W-1:0]    scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic [PTR_W-1:0]    src_ptr_reg, src_ptr_next;
    logic [PTR_W-1:0]    dst_ptr_reg, dst_ptr_next;
    logic [CNT_W-1:0]    remain_reg, remain_next;
    response_t           resp_reg, resp_next;

    // The one shared comparator of the search walk
    logic id_match;
    logic scan_last;

    assign id_match  = (rd_data_reg == id_reg);
    assign scan_last = ((scan_cnt_reg + ONE_CNT) == count_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_store[wr_addr] <= wr_data;
        end
        rd_data_reg <= id_store[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        scan_ptr_reg <= scan_ptr_next;
        scan_cnt_reg <= scan_cnt_next;
        src_ptr_reg  <= src_ptr_next;
        dst_ptr_reg  <= dst_ptr_next;
        remain_reg   <= remain_next;
        resp_reg     <= resp_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        done_next     = 1'b0;
        op_next       = op_reg;
        id_next       = id_reg;
        scan_ptr_next = scan_ptr_reg;
        scan_cnt_next = scan_cnt_reg;
        src_ptr_next  = src_ptr_reg;
        dst_ptr_next  = dst_ptr_reg;
        remain_next   = remain_reg;
        resp_next     = resp_reg;
        wr_en         = 1'b0;
        wr_addr       = tail_reg;
        wr_data       = id_reg;
        rd_addr       = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = request.operation;
                    id_next    = ID_WIDTH'(request.buffer_id);
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (op_reg)
                    OP_APPEND:
                    begin
                        resp_next.result_id = '0;
                        done_next           = 1'b1;
                        state_next          = S_IDLE;
                        if (count_reg == FULL_CNT)
                        begin
                            // Drop the id
                            resp_next.status = ST_FULL;
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            wr_addr          = tail_reg;
                            wr_data          = id_reg;
                            tail_next        = ptr_inc(tail_reg);
                            count_next       = count_reg + ONE_CNT;
                            resp_next.status = ST_OK;
                        end
                    end

                    OP_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            resp_next.result_id = '0;
                            resp_next.status    = ST_EMPTY;
                            done_next           = 1'b1;
                            state_next          = S_IDLE;
                        end
                        else
                        begin
                            rd_addr    = head_reg;
                            state_next = S_POP_WAIT;
                        end
                    end

                    OP_MOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            resp_next.result_id = '0;
                            resp_next.status    = ST_NOT_FOUND;
                            done_next           = 1'b1;
                            state_next          = S_IDLE;
                        end
                        else
                        begin
                            rd_addr       = head_reg;
                            scan_ptr_next = head_reg;
                            scan_cnt_next = '0;
                            state_next    = S_SEARCH;
                        end
                    end

                    default:
                    begin
                        // Unused code: answer ok, change nothing
                        resp_next.result_id = '0;
                        resp_next.status    = ST_OK;
                        done_next           = 1'b1;
                        state_next          = S_IDLE;
                    end
                endcase
            end

            S_POP_WAIT:
            begin
                resp_next.result_id = PORT_ID_W'(rd_data_reg);
                resp_next.status    = ST_OK;
                head_next           = ptr_inc(head_reg);
                count_next          = count_reg - ONE_CNT;
                done_next           = 1'b1;
                state_next          = S_IDLE;
            end

            S_SEARCH:
            begin
                if (id_match && scan_last)
                begin
                    // Already at the tail: order stays as it is
                    resp_next.result_id = '0;
                    resp_next.status    = ST_OK;
                    done_next           = 1'b1;
                    state_next          = S_IDLE;
                end
                else if (id_match)
                begin
                    dst_ptr_next = scan_ptr_reg;
                    src_ptr_next = ptr_inc(scan_ptr_reg);
                    rd_addr      = ptr_inc(scan_ptr_reg);
                    remain_next  = count_reg - scan_cnt_reg - ONE_CNT;
                    state_next   = S_SHIFT;
                end
                else if (scan_last)
                begin
                    resp_next.result_id = '0;
                    resp_next.status    = ST_NOT_FOUND;
                    done_next           = 1'b1;
                    state_next          = S_IDLE;
                end
                else
                begin
                    scan_ptr_next = ptr_inc(scan_ptr_reg);
                    scan_cnt_next = scan_cnt_reg + ONE_CNT;
                    rd_addr       = ptr_inc(scan_ptr_reg);
                end
            end

            S_SHIFT:
            begin
                // Close the gap: move one entry a cycle toward the head
                wr_en   = 1'b1;
                wr_addr = dst_ptr_reg;
                wr_data = rd_data_reg;
                if (remain_reg == ONE_CNT)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    dst_ptr_next = src_ptr_reg;
                    src_ptr_next = ptr_inc(src_ptr_reg);
                    rd_addr      = ptr_inc(src_ptr_reg);
                    remain_next  = remain_reg - ONE_CNT;
                end
            end

            S_PLACE:
            begin
                // The last source slot is the tail slot
                wr_en               = 1'b1;
                wr_addr             = src_ptr_reg;
                wr_data             = id_reg;
                resp_next.result_id = '0;
                resp_next.status    = ST_OK;
                done_next           = 1'b1;
                state_next          = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
        begin
            resp_next.length = PORT_LEN_W'(count_next);
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign response = resp_reg;

endmodule

@@ verif/testbench.sv @@
module testbench;
    import lru_pkg::*;

    // Block configuration under test; matches the defaults of the DUT
    localparam int LIST_DEPTH = DEFAULT_LIST_DEPTH;
    localparam int ID_WIDTH   = DEFAULT_ID_WIDTH;
    localparam logic [PORT_ID_W-1:0] ID_MASK = PORT_ID_W'((64'd1 << ID_WIDTH) - 64'd1);

    // Operation code the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_CHUNKS    = 6;
    localparam int ITEMS_PER_CHUNK  = 250;
    localparam int BIAS_SPAN        = 80;
    localparam int SETTLE_CYCLES    = 40;
    localparam int MAX_PRINTED_ERRS = 100;

    typedef enum int {
        GAP_NONE,
        GAP_SHORT,
        GAP_LONG
    } gap_mode_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    request_t  request = '0;
    logic      busy;
    logic      done;
    response_t response;

    // Shadow of the id list, head at index 0, and the responses still owed
    logic [PORT_ID_W-1:0] list_ids[$];
    response_t            awaited_resp[$];

    int unsigned err_count  = 0;
    int unsigned burst_left = 0;
    gap_mode_t   gap_mode   = GAP_NONE;

    lru_order_list dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (about 1500 items, each with
    // its work and at most the longest gap of the pacing)
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Count a failure; cap the printout so a broken block cannot flood the log
    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTED_ERRS)
            $display("%0t: MISMATCH %s", $time, msg);
    endtask

    // Position of the first entry equal to id, or -1 when absent
    function automatic int find_id_pos(input logic [PORT_ID_W-1:0] id);
        for (int i = 0; i < list_ids.size(); i++)
            if (list_ids[i] == id)
                return i;
        return -1;
    endfunction

    // Apply one operation to the shadow list and return the response it owes
    function automatic response_t predict_list_op(input request_t req);
        response_t            rsp;
        logic [PORT_ID_W-1:0] id;
        int                   pos;
        rsp = '0;
        rsp.status = ST_OK;
        id = req.buffer_id & ID_MASK;
        case (req.operation)
            OP_APPEND:
            begin
                if (list_ids.size() >= LIST_DEPTH)
                    rsp.status = ST_FULL;
                else
                    list_ids.push_back(id);
            end
            OP_POP:
            begin
                if (list_ids.size() == 0)
                    rsp.status = ST_EMPTY;
                else
                    rsp.result_id = list_ids.pop_front();
            end
            OP_MOVE:
            begin
                // Take the first match out and put it back at the tail
                pos = find_id_pos(id);
                if (pos < 0)
                begin
                    rsp.status = ST_NOT_FOUND;
                end
                else
                begin
                    list_ids.delete(pos);
                    list_ids.push_back(id);
                end
            end
            default: ;
        endcase
        rsp.length = PORT_LEN_W'(list_ids.size());
        return rsp;
    endfunction

    // Draw an id that is not in the list at the moment
    function automatic logic [PORT_ID_W-1:0] pick_absent_id();
        logic [PORT_ID_W-1:0] id;
        do
            id = PORT_ID_W'($urandom_range(0, 1023));
        while (find_id_pos(id & ID_MASK) >= 0);
        return id;
    endfunction

    // Sender pacing: bursts of random length, separated by gaps whose size
    // depends on the current gap mode. Drop start only for a real gap.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            case (gap_mode)
                GAP_NONE:  gap = 0;
                GAP_SHORT: gap = $urandom_range(0, 4);
                default:   gap = $urandom_range(0, 40);
            endcase
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Present one item and hold it until the block takes it. Leave start
    // high on return so a following item goes out back to back.
    task automatic send_item(input logic [1:0] op, input logic [PORT_ID_W-1:0] id);
        request_t req;
        req.operation = op;
        req.buffer_id = id;
        pace_sender();
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        // Accepted at this edge: record what it owes
        awaited_resp.push_back(predict_list_op(req));
    endtask

    // Stop sending and wait until every owed response has arrived; always
    // advance at least one edge so start is not driven twice in one step
    task automatic wait_all_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (awaited_resp.size() != 0);
    endtask

    // Compare each response with the oldest one owed, field by field
    always @(posedge clk)
    begin
        response_t want;
        if (rst_n && done === 1'b1)
        begin
            if (awaited_resp.size() == 0)
            begin
                report_mismatch($sformatf("response %h with nothing pending", response));
            end
            else
            begin
                want = awaited_resp.pop_front();
                if (response.result_id !== want.result_id)
                    report_mismatch($sformatf("result_id got %0d want %0d",
                                              response.result_id, want.result_id));
                if (response.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              response.status, want.status));
                if (response.length !== want.length)
                    report_mismatch($sformatf("length got %0d want %0d",
                                              response.length, want.length));
            end
        end
    end

    // Pop, move and the unused code on an empty list
    task automatic test_empty_list();
        send_item(OP_POP, 10'h3FF);
        send_item(OP_MOVE, 10'h3FF);
        send_item(OP_UNUSED, 10'h155);
        wait_all_results();
    endtask

    // Fill to capacity with extreme ids and a duplicate, then overflow
    task automatic test_fill_to_full();
        logic [PORT_ID_W-1:0] id;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            case (i)
                0:       id = '0;
                1:       id = 10'h3FF;
                2:       id = 10'h155;
                3:       id = 10'h2AA;
                4:       id = 10'h3FF;
                default: id = PORT_ID_W'($urandom_range(0, 1023));
            endcase
            send_item(OP_APPEND, id);
        end
        // The list is full now: this append must be dropped
        send_item(OP_APPEND, 10'h2AA);
        wait_all_results();
    endtask

    // Move at the head, at the tail, of a duplicated id and of an absent id; then unused code and pop
    task automatic test_move_cases();
        send_item(OP_MOVE, list_ids[0]);
        // The id just moved sits at the tail: order must not change
        send_item(OP_MOVE, list_ids[list_ids.size() - 1]);
        // All-ones is in the list at least twice; only the first copy moves
        send_item(OP_MOVE, 10'h3FF);
        send_item(OP_MOVE, pick_absent_id());
        send_item(OP_UNUSED, 10'h2AA);
        send_item(OP_POP, 10'h000);
        wait_all_results();
    endtask

    // One random item; the fill bias pushes the list toward full or empty
    task automatic send_random_item(input bit fill_bias);
        int unsigned          roll;
        int unsigned          lim_append;
        int unsigned          lim_pop;
        int unsigned          lim_move;
        int unsigned          lim_absent;
        logic [PORT_ID_W-1:0] id;
        roll = $urandom_range(0, 99);
        if (fill_bias)
        begin
            lim_append = 55; lim_pop = 65; lim_move = 93; lim_absent = 98;
        end
        else
        begin
            lim_append = 20; lim_pop = 60; lim_move = 90; lim_absent = 97;
        end
        if (roll < lim_append)
        begin
            // A small id pool now and then yields duplicates in the list
            if ($urandom_range(0, 3) == 0)
                id = PORT_ID_W'($urandom_range(0, 7));
            else
                id = PORT_ID_W'($urandom_range(0, 1023));
            send_item(OP_APPEND, id);
        end
        else if (roll < lim_pop)
        begin
            send_item(OP_POP, PORT_ID_W'($urandom_range(0, 1023)));
        end
        else if (roll < lim_move)
        begin
            if (list_ids.size() == 0)
                id = PORT_ID_W'($urandom_range(0, 1023));
            else
                id = list_ids[$urandom_range(0, list_ids.size() - 1)];
            send_item(OP_MOVE, id);
        end
        else if (roll < lim_absent)
        begin
            send_item(OP_MOVE, pick_absent_id());
        end
        else
        begin
            send_item(OP_UNUSED, PORT_ID_W'($urandom_range(0, 1023)));
        end
    endtask

    // Random traffic in chunks, each with its own pacing; drain the block
    // completely between some chunks so items also start from an idle block
    task automatic test_random_traffic();
        for (int c = 0; c < RANDOM_CHUNKS; c++)
        begin
            case (c % 3)
                0:       gap_mode = GAP_NONE;
                1:       gap_mode = GAP_SHORT;
                default: gap_mode = GAP_LONG;
            endcase
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_CHUNK; n++)
                send_random_item(((n / BIAS_SPAN) % 2) == 0);
            if (c % 2 == 1)
                wait_all_results();
        end
        wait_all_results();
    endtask

    initial
    begin
        // Hold reset low, then release it on a rising edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_mode = GAP_SHORT;
        test_empty_list();
        test_fill_to_full();
        test_move_cases();
        test_random_traffic();

        // Let any stray response show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
